>>> design/resp_request_deframer_defines.svh
// ----------------------------------------------------------------------------
// Request deframer assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RESP_REQUEST_DEFRAMER_DEFINES_SVH
`define RESP_REQUEST_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
// checked outside reset
`define RRD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rrd assertion failed");
// checked at every edge, reset included
`define RRD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rrd assertion failed");
`else
`define RRD_ASSERT(lbl, clk, rst, prop)
`define RRD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> design/rrd_pkg.sv
// ----------------------------------------------------------------------------
// Request deframer package
// Shared types, character codes and widths.
// ----------------------------------------------------------------------------
package rrd_pkg;

   localparam int NUM_W = 21;
   localparam int IDX_W = 20;

   localparam logic [NUM_W-1:0] LIMIT_RESET = 21'd32768;
   localparam logic [NUM_W-1:0] NUM_ONE     = NUM_W'(1);

   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   typedef enum logic [3:0] {
      PH_STAR,
      PH_COUNT,
      PH_SKIP_COUNT,
      PH_DOLLAR,
      PH_LEN,
      PH_SKIP_LEN,
      PH_DATA,
      PH_TRAIL1,
      PH_TRAIL2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_STAR   = 2'd0,
      ERR_COUNT  = 2'd1,
      ERR_DOLLAR = 2'd2,
      ERR_LENGTH = 2'd3
   } error_type;

   typedef struct packed {
      logic digit;
      logic zero_first;
      logic invalid;
   } num_flags_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       data_byte;
      logic [IDX_W-1:0] arg_index;
      logic             is_name;
      logic [NUM_W-1:0] arg_length;
      logic             last;
      error_type        error_code;
   } result_type;

   // input stage <-> core handshake
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } in_item_type;

endpackage

>>> design/rrd_in_stage.sv
// ----------------------------------------------------------------------------
// Request deframer input stage
// Registers one request byte and holds it until the core takes it.
// ----------------------------------------------------------------------------
module rrd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   input  logic                 consume,
   output rrd_pkg::in_item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign req_stall = valid_ff && !consume;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign item.valid   = valid_ff;
   assign item.rx_byte = byte_ff;

endmodule

>>> design/rrd_core.sv
// ----------------------------------------------------------------------------
// Request deframer core
// Per-byte parse state machine, number checker and limit register.
// ----------------------------------------------------------------------------
`include "resp_request_deframer_defines.svh"

module rrd_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic [rrd_pkg::NUM_W-1:0]        csr_length_limit,
   input  rrd_pkg::in_item_type             item,
   input  logic                             out_free,
   output logic                             consume,
   output logic                             res_valid,
   output rrd_pkg::result_type              res
);

   rrd_pkg::phase_type              phase_ff, phase_in;
   logic [rrd_pkg::NUM_W-1:0]       limit_ff;
   logic [rrd_pkg::NUM_W-1:0]       args_rem_ff, args_rem_in;
   logic [rrd_pkg::NUM_W-1:0]       bulk_rem_ff, bulk_rem_in;
   logic [rrd_pkg::NUM_W-1:0]       accum_ff, accum_in;
   rrd_pkg::num_flags_type          flags_ff, flags_in;
   logic [rrd_pkg::NUM_W-1:0]       arg_cnt_ff, arg_cnt_in;
   logic                            name_shift_ff, name_shift_in;
   logic                            halted_ff, halted_in;

   logic [7:0]                      b;
   logic                            is_digit;
   logic [3:0]                      digit_val;
   logic [rrd_pkg::NUM_W+3:0]       prod;
   rrd_pkg::num_flags_type          dig_flags;
   logic [rrd_pkg::NUM_W-1:0]       dig_accum;
   logic                            num_ok;
   logic                            is_name;
   logic                            shift_now;
   logic                            is_cr;
   logic                            has_result;
   logic [7:0]                      data_val;

   assign b         = item.rx_byte;
   assign is_cr     = (b == rrd_pkg::CHAR_CR);
   assign is_digit  = (b >= rrd_pkg::CHAR_ZERO) && (b <= rrd_pkg::CHAR_NINE);
   assign digit_val = b[3:0];
   assign prod      = ({4'd0, accum_ff} << 3) + ({4'd0, accum_ff} << 1)
                    + {{rrd_pkg::NUM_W{1'b0}}, digit_val};
   assign num_ok    = flags_ff.digit && !flags_ff.invalid;
   assign is_name   = (arg_cnt_ff == '0);
   assign shift_now = name_shift_ff
                   || (is_name && (accum_ff == bulk_rem_ff)
                       && (b >= rrd_pkg::CHAR_UP_A) && (b <= rrd_pkg::CHAR_UP_Z));
   assign data_val  = (is_name && shift_now) ? (b + rrd_pkg::CASE_OFFSET) : b;

   // digit accumulation
   always_comb begin
      dig_flags = flags_ff;
      dig_accum = accum_ff;
      if (!is_digit) begin
         dig_flags.invalid = 1'b1;
      end else if (!dig_flags.digit) begin
         dig_flags.digit      = 1'b1;
         dig_flags.zero_first = (digit_val == 4'd0);
      end else if (dig_flags.zero_first) begin
         dig_flags.invalid = 1'b1;
      end
      if (!dig_flags.invalid) begin
         if (prod > {4'd0, limit_ff}) begin
            dig_flags.invalid = 1'b1;
         end else begin
            dig_accum = prod[rrd_pkg::NUM_W-1:0];
         end
      end
   end

   // result
   always_comb begin
      has_result = 1'b0;
      res        = '0;
      if (!halted_ff) begin
         case (phase_ff)
            rrd_pkg::PH_STAR: begin
               if (b != rrd_pkg::CHAR_STAR) begin
                  has_result     = 1'b1;
                  res.kind       = rrd_pkg::KIND_ERROR;
                  res.error_code = rrd_pkg::ERR_STAR;
               end
            end
            rrd_pkg::PH_COUNT: begin
               if (is_cr && !(num_ok && accum_ff != '0)) begin
                  has_result     = 1'b1;
                  res.kind       = rrd_pkg::KIND_ERROR;
                  res.error_code = rrd_pkg::ERR_COUNT;
               end
            end
            rrd_pkg::PH_DOLLAR: begin
               if (b != rrd_pkg::CHAR_DOLLAR) begin
                  has_result     = 1'b1;
                  res.kind       = rrd_pkg::KIND_ERROR;
                  res.error_code = rrd_pkg::ERR_DOLLAR;
               end
            end
            rrd_pkg::PH_LEN: begin
               if (is_cr && !num_ok) begin
                  has_result     = 1'b1;
                  res.kind       = rrd_pkg::KIND_ERROR;
                  res.error_code = rrd_pkg::ERR_LENGTH;
               end
            end
            rrd_pkg::PH_DATA: begin
               has_result     = 1'b1;
               res.kind       = rrd_pkg::KIND_DATA;
               res.data_byte  = data_val;
               res.arg_index  = arg_cnt_ff[rrd_pkg::IDX_W-1:0];
               res.is_name    = is_name;
               res.arg_length = accum_ff;
            end
            rrd_pkg::PH_TRAIL2: begin
               has_result     = 1'b1;
               res.kind       = rrd_pkg::KIND_END;
               res.arg_index  = arg_cnt_ff[rrd_pkg::IDX_W-1:0];
               res.is_name    = is_name;
               res.arg_length = accum_ff;
               res.last       = (args_rem_ff == {{(rrd_pkg::NUM_W-1){1'b0}}, 1'b1});
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
      end
   end

   assign consume   = item.valid && (!has_result || out_free);
   assign res_valid = consume && has_result;

   // next state
   always_comb begin
      phase_in      = phase_ff;
      args_rem_in   = args_rem_ff;
      bulk_rem_in   = bulk_rem_ff;
      accum_in      = accum_ff;
      flags_in      = flags_ff;
      arg_cnt_in    = arg_cnt_ff;
      name_shift_in = name_shift_ff;
      halted_in     = halted_ff;
      if (consume && !halted_ff) begin
         case (phase_ff)
            rrd_pkg::PH_STAR: begin
               if (b != rrd_pkg::CHAR_STAR) begin
                  halted_in = 1'b1;
               end else begin
                  accum_in      = '0;
                  flags_in      = '0;
                  name_shift_in = 1'b0;
                  arg_cnt_in    = '0;
                  phase_in      = rrd_pkg::PH_COUNT;
               end
            end
            rrd_pkg::PH_COUNT: begin
               if (!is_cr) begin
                  accum_in = dig_accum;
                  flags_in = dig_flags;
               end else if (!(num_ok && accum_ff != '0)) begin
                  halted_in = 1'b1;
               end else begin
                  args_rem_in = accum_ff;
                  phase_in    = rrd_pkg::PH_SKIP_COUNT;
               end
            end
            rrd_pkg::PH_SKIP_COUNT: begin
               phase_in = rrd_pkg::PH_DOLLAR;
            end
            rrd_pkg::PH_DOLLAR: begin
               if (b != rrd_pkg::CHAR_DOLLAR) begin
                  halted_in = 1'b1;
               end else begin
                  accum_in = '0;
                  flags_in = '0;
                  phase_in = rrd_pkg::PH_LEN;
               end
            end
            rrd_pkg::PH_LEN: begin
               if (!is_cr) begin
                  accum_in = dig_accum;
                  flags_in = dig_flags;
               end else if (!num_ok) begin
                  halted_in = 1'b1;
               end else begin
                  bulk_rem_in = accum_ff;
                  phase_in    = rrd_pkg::PH_SKIP_LEN;
               end
            end
            rrd_pkg::PH_SKIP_LEN: begin
               phase_in = (bulk_rem_ff != '0) ? rrd_pkg::PH_DATA : rrd_pkg::PH_TRAIL1;
            end
            rrd_pkg::PH_DATA: begin
               name_shift_in = shift_now;
               bulk_rem_in   = bulk_rem_ff - rrd_pkg::NUM_ONE;
               if (bulk_rem_in == '0) begin
                  phase_in = rrd_pkg::PH_TRAIL1;
               end
            end
            rrd_pkg::PH_TRAIL1: begin
               phase_in = rrd_pkg::PH_TRAIL2;
            end
            rrd_pkg::PH_TRAIL2: begin
               args_rem_in = args_rem_ff - rrd_pkg::NUM_ONE;
               arg_cnt_in  = arg_cnt_ff + rrd_pkg::NUM_ONE;
               phase_in    = (args_rem_in == '0) ? rrd_pkg::PH_STAR : rrd_pkg::PH_DOLLAR;
            end
            default: begin
               phase_in = rrd_pkg::PH_STAR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= rrd_pkg::PH_STAR;
         limit_ff      <= rrd_pkg::LIMIT_RESET;
         args_rem_ff   <= '0;
         bulk_rem_ff   <= '0;
         accum_ff      <= '0;
         flags_ff      <= '0;
         arg_cnt_ff    <= '0;
         name_shift_ff <= 1'b0;
         halted_ff     <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         if (csr_valid) begin
            limit_ff <= csr_length_limit;
         end
         args_rem_ff   <= args_rem_in;
         bulk_rem_ff   <= bulk_rem_in;
         accum_ff      <= accum_in;
         flags_ff      <= flags_in;
         arg_cnt_ff    <= arg_cnt_in;
         name_shift_ff <= name_shift_in;
         halted_ff     <= halted_in;
      end
   end

   `RRD_ASSERT(a_halt_sticky, clock, reset, halted_ff |=> halted_ff)
   `RRD_ASSERT_ALWAYS(a_halt_silent, clock, halted_ff |-> !res_valid)
   `RRD_ASSERT(a_err_halts, clock, reset, (res_valid && res.kind == rrd_pkg::KIND_ERROR) |=> halted_ff)
   `RRD_ASSERT(a_last_restart, clock, reset, (res_valid && res.last) |=> (phase_ff == rrd_pkg::PH_STAR))
   `RRD_ASSERT(a_data_left, clock, reset, (phase_ff == rrd_pkg::PH_DATA) |-> (bulk_rem_ff != '0))

endmodule

>>> design/rrd_out_stage.sv
// ----------------------------------------------------------------------------
// Request deframer output stage
// Result register; refills while the downstream takes the current result.
// ----------------------------------------------------------------------------
module rrd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   input  rrd_pkg::result_type res,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rrd_pkg::result_type rsp
);

   logic                valid_ff, valid_in;
   rrd_pkg::result_type rsp_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = res_valid || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> design/resp_request_deframer.sv
// ----------------------------------------------------------------------------
// Multibulk request deframer, top level
// Takes request bytes one per cycle and emits argument bytes, argument-end
// markers and a single protocol error report.
// ----------------------------------------------------------------------------
// One request byte is accepted every clock cycle while the result side keeps
// up. A byte accepted at one edge is parsed in the next cycle and its result,
// if any, is loaded into the result register at the first edge at which that
// register is free to take it, and is presented on rsp_* from there. req_stall
// rises only when a result waits in the result register under rsp_stall and
// the byte held in the input register also makes a result. Bytes that make
// no result (markers, digits, CR, skipped bytes) pass even under rsp_stall.
// After a protocol error every byte is consumed with no result until reset.
// The length limit is written through the csr port, which is always ready;
// write it only while the block is idle.
module resp_request_deframer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [7:0]                        rsp_data_byte,
   output logic [rrd_pkg::IDX_W-1:0]         rsp_arg_index,
   output logic                              rsp_is_name,
   output logic [rrd_pkg::NUM_W-1:0]         rsp_arg_length,
   output logic                              rsp_last,
   output logic [1:0]                        rsp_error_code,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rrd_pkg::NUM_W-1:0]         csr_length_limit
);

   rrd_pkg::in_item_type item;
   rrd_pkg::result_type  res;
   rrd_pkg::result_type  rsp;
   logic                 consume;
   logic                 res_valid;
   logic                 out_free;

   assign csr_ready = 1'b1;

   rrd_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .consume     (consume),
      .item        (item)
   );

   rrd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid && csr_ready),
      .csr_length_limit (csr_length_limit),
      .item             (item),
      .out_free         (out_free),
      .consume          (consume),
      .res_valid        (res_valid),
      .res              (res)
   );

   rrd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_kind       = rsp.kind;
   assign rsp_data_byte  = rsp.data_byte;
   assign rsp_arg_index  = rsp.arg_index;
   assign rsp_is_name    = rsp.is_name;
   assign rsp_arg_length = rsp.arg_length;
   assign rsp_last       = rsp.last;
   assign rsp_error_code = rsp.error_code;

endmodule

>>> dv/resp_request_deframer_tb.sv
// ----------------------------------------------------------------------------
// Request deframer testbench
// Feeds multibulk request bytes with random bursts and gaps against a random
// stall pattern, predicts every argument byte, argument end and error report
// from an in-bench parser model, and compares them in order. Ends with one
// broken request, since an error halts the block until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module resp_request_deframer_tb;

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_LC_A = 8'h61;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 45;
   localparam int MAX_REPORTS = 10;
   localparam int EXP_DEPTH = 64;

   typedef logic [rrd_pkg::NUM_W-1:0] num_type;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_type;

   typedef struct packed {
      logic [7:0]          rx;
      logic                typed;
      rrd_pkg::result_type want;
   } plan_row_type;

   localparam rrd_pkg::result_type NO_RES = '0;

   // two requests; skipped bytes carry odd values on purpose
   localparam plan_row_type PLAN [28] = '{
      '{rrd_pkg::CHAR_STAR, 1'b0, NO_RES},
      '{8'h32, 1'b0, NO_RES},
      '{rrd_pkg::CHAR_CR, 1'b0, NO_RES},
      '{8'hFF, 1'b0, NO_RES},
      '{rrd_pkg::CHAR_DOLLAR, 1'b0, NO_RES},
      '{8'h31, 1'b0, NO_RES},
      '{rrd_pkg::CHAR_CR, 1'b0, NO_RES},
      '{8'h00, 1'b0, NO_RES},
      '{rrd_pkg::CHAR_UP_A, 1'b1,
        '{rrd_pkg::KIND_DATA, CHAR_LC_A, 20'd0, 1'b1, 21'd1, 1'b0, rrd_pkg::ERR_STAR}},
      '{rrd_pkg::CHAR_CR, 1'b0, NO_RES},
      '{CHAR_LF, 1'b1,
        '{rrd_pkg::KIND_END, 8'h00, 20'd0, 1'b1, 21'd1, 1'b0, rrd_pkg::ERR_STAR}},
      '{rrd_pkg::CHAR_DOLLAR, 1'b0, NO_RES},
      '{rrd_pkg::CHAR_ZERO, 1'b0, NO_RES},
      '{rrd_pkg::CHAR_CR, 1'b0, NO_RES},
      '{CHAR_LF, 1'b0, NO_RES},
      '{8'h5A, 1'b0, NO_RES},
      '{8'h7F, 1'b1,
        '{rrd_pkg::KIND_END, 8'h00, 20'd1, 1'b0, 21'd0, 1'b1, rrd_pkg::ERR_STAR}},
      '{rrd_pkg::CHAR_STAR, 1'b0, NO_RES},
      '{8'h31, 1'b0, NO_RES},
      '{rrd_pkg::CHAR_CR, 1'b0, NO_RES},
      '{CHAR_LF, 1'b0, NO_RES},
      '{rrd_pkg::CHAR_DOLLAR, 1'b0, NO_RES},
      '{8'h31, 1'b0, NO_RES},
      '{rrd_pkg::CHAR_CR, 1'b0, NO_RES},
      '{CHAR_LF, 1'b0, NO_RES},
      '{8'hFF, 1'b1,
        '{rrd_pkg::KIND_DATA, 8'hFF, 20'd0, 1'b1, 21'd1, 1'b0, rrd_pkg::ERR_STAR}},
      '{rrd_pkg::CHAR_CR, 1'b0, NO_RES},
      '{CHAR_LF, 1'b1,
        '{rrd_pkg::KIND_END, 8'h00, 20'd0, 1'b1, 21'd1, 1'b1, rrd_pkg::ERR_STAR}}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_rx_byte = 8'h00;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_kind;
   logic [7:0]                rsp_data_byte;
   logic [rrd_pkg::IDX_W-1:0] rsp_arg_index;
   logic                      rsp_is_name;
   num_type                   rsp_arg_length;
   logic                      rsp_last;
   logic [1:0]                rsp_error_code;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   num_type                   csr_length_limit = '0;

   resp_request_deframer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_arg_index    (rsp_arg_index),
      .rsp_is_name      (rsp_is_name),
      .rsp_arg_length   (rsp_arg_length),
      .rsp_last         (rsp_last),
      .rsp_error_code   (rsp_error_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_length_limit (csr_length_limit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser model state
   rrd_pkg::phase_type phase_q = rrd_pkg::PH_STAR;
   num_type            limit_q = rrd_pkg::LIMIT_RESET;
   num_type            args_left = '0;
   num_type            bytes_left = '0;
   num_type            num_val = '0;
   logic               has_digit = 1'b0;
   logic               lead_zero = 1'b0;
   logic               bad_num = 1'b0;
   num_type            arg_pos = '0;
   logic               shift_name = 1'b0;
   logic               halted_q = 1'b0;

   // expected results, in order; exp_wr - exp_rd is the number outstanding
   rrd_pkg::result_type exp_fifo [EXP_DEPTH];
   int                  exp_wr = 0;
   int                  exp_rd = 0;
   int                  fault_count = 0;
   int                  cycle_count = 0;
   int                  burst_left = 0;
   int                  bytes_sent = 0;

   function automatic void note_result(input rrd_pkg::result_type r);
      exp_fifo[exp_wr % EXP_DEPTH] = r;
      exp_wr++;
   endfunction

   function automatic void clear_number();
      num_val = '0;
      has_digit = 1'b0;
      lead_zero = 1'b0;
      bad_num = 1'b0;
   endfunction

   function automatic void take_digit(input logic [7:0] b);
      logic [63:0] v;
      logic [3:0]  d;
      if (b < rrd_pkg::CHAR_ZERO || b > rrd_pkg::CHAR_NINE) begin
         bad_num = 1'b1;
      end else begin
         d = 4'(b - rrd_pkg::CHAR_ZERO);
         if (!has_digit) begin
            has_digit = 1'b1;
            if (d == 4'd0) lead_zero = 1'b1;
         end else if (lead_zero) begin
            bad_num = 1'b1;
         end
         if (!bad_num) begin
            v = 64'(num_val) * 64'(10) + 64'(d);
            if (v > 64'(limit_q)) bad_num = 1'b1;
            else num_val = v[rrd_pkg::NUM_W-1:0];
         end
      end
   endfunction

   function automatic bit number_good(input bit zero_ok);
      if (!has_digit || bad_num) return 1'b0;
      if (!zero_ok && num_val == '0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit halt_with(input rrd_pkg::error_type code,
                                    output rrd_pkg::result_type res);
      halted_q = 1'b1;
      res = '0;
      res.kind = rrd_pkg::KIND_ERROR;
      res.error_code = code;
      return 1'b1;
   endfunction

   // advances the model by one request byte; returns 1 when a result is due
   function automatic bit parse_byte(input logic [7:0] b, output rrd_pkg::result_type res);
      num_type pos;
      logic    nm;
      res = '0;
      if (halted_q) return 1'b0;
      case (phase_q)
         rrd_pkg::PH_STAR: begin
            if (b != rrd_pkg::CHAR_STAR) return halt_with(rrd_pkg::ERR_STAR, res);
            clear_number();
            shift_name = 1'b0;
            arg_pos = '0;
            phase_q = rrd_pkg::PH_COUNT;
         end
         rrd_pkg::PH_COUNT: begin
            if (b != rrd_pkg::CHAR_CR) begin
               take_digit(b);
            end else begin
               if (!number_good(1'b0)) return halt_with(rrd_pkg::ERR_COUNT, res);
               args_left = num_val;
               phase_q = rrd_pkg::PH_SKIP_COUNT;
            end
         end
         rrd_pkg::PH_SKIP_COUNT: phase_q = rrd_pkg::PH_DOLLAR;
         rrd_pkg::PH_DOLLAR: begin
            if (b != rrd_pkg::CHAR_DOLLAR) return halt_with(rrd_pkg::ERR_DOLLAR, res);
            clear_number();
            phase_q = rrd_pkg::PH_LEN;
         end
         rrd_pkg::PH_LEN: begin
            if (b != rrd_pkg::CHAR_CR) begin
               take_digit(b);
            end else begin
               if (!number_good(1'b1)) return halt_with(rrd_pkg::ERR_LENGTH, res);
               bytes_left = num_val;
               phase_q = rrd_pkg::PH_SKIP_LEN;
            end
         end
         rrd_pkg::PH_SKIP_LEN: begin
            phase_q = (bytes_left != '0) ? rrd_pkg::PH_DATA : rrd_pkg::PH_TRAIL1;
         end
         rrd_pkg::PH_DATA: begin
            nm = (arg_pos == '0);
            pos = num_val - bytes_left;
            if (nm && pos == '0 && b >= rrd_pkg::CHAR_UP_A && b <= rrd_pkg::CHAR_UP_Z)
               shift_name = 1'b1;
            res.kind = rrd_pkg::KIND_DATA;
            res.data_byte = (nm && shift_name) ? b + rrd_pkg::CASE_OFFSET : b;
            res.arg_index = arg_pos[rrd_pkg::IDX_W-1:0];
            res.is_name = nm;
            res.arg_length = num_val;
            bytes_left = bytes_left - rrd_pkg::NUM_ONE;
            if (bytes_left == '0) phase_q = rrd_pkg::PH_TRAIL1;
            return 1'b1;
         end
         rrd_pkg::PH_TRAIL1: phase_q = rrd_pkg::PH_TRAIL2;
         rrd_pkg::PH_TRAIL2: begin
            res.kind = rrd_pkg::KIND_END;
            res.arg_index = arg_pos[rrd_pkg::IDX_W-1:0];
            res.is_name = (arg_pos == '0);
            res.arg_length = num_val;
            args_left = args_left - rrd_pkg::NUM_ONE;
            arg_pos = arg_pos + rrd_pkg::NUM_ONE;
            res.last = (args_left == '0);
            phase_q = res.last ? rrd_pkg::PH_STAR : rrd_pkg::PH_DOLLAR;
            return 1'b1;
         end
         default: phase_q = rrd_pkg::PH_STAR;
      endcase
      return 1'b0;
   endfunction

   // sender: random bursts separated by random gaps
   task automatic send_byte(input logic [7:0] b, input bit fixed = 1'b0,
                            input rrd_pkg::result_type fixed_res = '0);
      int                  gap;
      rrd_pkg::result_type res;
      bit                  got;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      got = parse_byte(b, res);
      if (fixed) note_result(fixed_res);
      else if (got) note_result(res);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_limit(input num_type v);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_length_limit <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      limit_q = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_decimal(input int unsigned v);
      logic [7:0]  digs [10];
      int unsigned rest;
      int          cnt;
      rest = v;
      cnt = 0;
      do begin
         digs[cnt] = rrd_pkg::CHAR_ZERO + 8'(rest % 10);
         cnt++;
         rest = rest / 10;
      end while (rest != 0);
      for (int i = cnt - 1; i >= 0; i--) send_byte(digs[i]);
   endtask

   function automatic logic [7:0] filler(input logic [7:0] usual);
      return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : usual;
   endfunction

   function automatic int unsigned pick_length();
      int unsigned cap;
      int unsigned r;
      cap = (limit_q < 40) ? limit_q : 40;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(0, (cap < 8) ? cap : 8);
      if (r < 9) return $urandom_range(0, cap);
      return cap;
   endfunction

   task automatic send_arg(input bit nm, input int unsigned len);
      logic [7:0] b;
      send_byte(rrd_pkg::CHAR_DOLLAR);
      send_decimal(len);
      send_byte(rrd_pkg::CHAR_CR);
      send_byte(filler(CHAR_LF));
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         if (nm && i == 0 && $urandom_range(0, 1) == 1)
            b = 8'($urandom_range(rrd_pkg::CHAR_UP_A, rrd_pkg::CHAR_UP_Z));
         send_byte(b);
      end
      send_byte(filler(rrd_pkg::CHAR_CR));
      send_byte(filler(CHAR_LF));
   endtask

   task automatic send_header(input int unsigned n);
      send_byte(rrd_pkg::CHAR_STAR);
      send_decimal(n);
      send_byte(rrd_pkg::CHAR_CR);
      send_byte(filler(CHAR_LF));
   endtask

   task automatic send_request();
      int unsigned top;
      int unsigned n;
      top = (limit_q < 6) ? limit_q : 6;
      if (limit_q >= 12 && $urandom_range(0, 9) == 0) top = 12;
      n = $urandom_range(1, top);
      send_header(n);
      for (int a = 0; a < n; a++) send_arg(a == 0, pick_length());
   endtask

   function automatic logic [7:0] pick_junk();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while ((b >= rrd_pkg::CHAR_ZERO && b <= rrd_pkg::CHAR_NINE) || b == rrd_pkg::CHAR_CR);
      return b;
   endfunction

   task automatic send_bad_number(input bit is_count);
      case ($urandom_range(0, 4))
         0: ;
         1: begin
            send_byte(rrd_pkg::CHAR_ZERO);
            if (!is_count || $urandom_range(0, 1) == 1)
               send_byte(rrd_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
         end
         2: begin
            send_byte(($urandom_range(0, 1) == 1) ? CHAR_MINUS : CHAR_PLUS);
            send_decimal($urandom_range(1, 9));
         end
         3: send_decimal(limit_q + 1 + $urandom_range(0, 100));
         default: begin
            send_byte(rrd_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)));
            send_byte(pick_junk());
            send_byte(rrd_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
         end
      endcase
   endtask

   // one protocol error, then bytes the halted block must swallow
   task automatic send_broken();
      rrd_pkg::error_type code;
      logic [7:0]         b;
      int unsigned        n;
      int unsigned        k;
      if ($urandom_range(0, 3) == 0) begin
         set_limit('0);
         send_byte(rrd_pkg::CHAR_STAR);
         send_decimal($urandom_range(0, 99));
         send_byte(rrd_pkg::CHAR_CR);
      end else begin
         set_limit(num_type'($urandom_range(1, 50)));
         if ($urandom_range(0, 1) == 1) send_request();
         code = rrd_pkg::error_type'($urandom_range(0, 3));
         case (code)
            rrd_pkg::ERR_STAR: begin
               do b = 8'($urandom_range(0, 255)); while (b == rrd_pkg::CHAR_STAR);
               send_byte(b);
            end
            rrd_pkg::ERR_COUNT: begin
               send_byte(rrd_pkg::CHAR_STAR);
               send_bad_number(1'b1);
               send_byte(rrd_pkg::CHAR_CR);
            end
            default: begin
               n = $urandom_range(1, (limit_q < 4) ? limit_q : 4);
               k = $urandom_range(0, n - 1);
               send_header(n);
               for (int a = 0; a < k; a++) send_arg(a == 0, pick_length());
               if (code == rrd_pkg::ERR_DOLLAR) begin
                  do b = 8'($urandom_range(0, 255)); while (b == rrd_pkg::CHAR_DOLLAR);
                  send_byte(b);
               end else begin
                  send_byte(rrd_pkg::CHAR_DOLLAR);
                  send_bad_number(1'b0);
                  send_byte(rrd_pkg::CHAR_CR);
               end
            end
         endcase
      end
      repeat (30) send_byte(8'($urandom_range(0, 255)));
   endtask

   // receiver stall pattern
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             run_left = 0;
   logic           run_hold = 1'b0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (stall_mode)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (run_left == 0) begin
               run_hold = ~run_hold;
               run_left = $urandom_range(1, 8);
            end
            run_left--;
            rsp_stall <= run_hold;
         end
      endcase
   end

   always @(posedge clock) begin
      rrd_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exp_wr == exp_rd) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
               $display("unexpected result: kind %0d byte %0h idx %0d", rsp_kind,
                        rsp_data_byte, rsp_arg_index);
         end else begin
            want = exp_fifo[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_kind !== want.kind || rsp_data_byte !== want.data_byte ||
                rsp_arg_index !== want.arg_index || rsp_is_name !== want.is_name ||
                rsp_arg_length !== want.arg_length || rsp_last !== want.last ||
                rsp_error_code !== want.error_code) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS) begin
                  $display("exp: kind %0d byte %0h idx %0d name %0d len %0d last %0d err %0d",
                           want.kind, want.data_byte, want.arg_index, want.is_name,
                           want.arg_length, want.last, want.error_code);
                  $display("act: kind %0d byte %0h idx %0d name %0d len %0d last %0d err %0d",
                           rsp_kind, rsp_data_byte, rsp_arg_index, rsp_is_name,
                           rsp_arg_length, rsp_last, rsp_error_code);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("resp_request_deframer verification failed");
         $finish;
      end
   end

   initial begin
      num_type phase_limits [6];
      int      start;
      phase_limits[0] = num_type'(1);
      phase_limits[1] = num_type'(1048576);
      phase_limits[2] = '1;
      phase_limits[3] = num_type'(20);
      phase_limits[4] = num_type'($urandom_range(2, 64));
      phase_limits[5] = num_type'($urandom_range(1, 2097151));
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (PLAN[i]) send_byte(PLAN[i].rx, PLAN[i].typed, PLAN[i].want);

      foreach (phase_limits[p]) begin
         set_limit(phase_limits[p]);
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) send_request();
      end

      send_broken();

      @(negedge clock);
      req_valid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (10) @(posedge clock);
      if (exp_wr != exp_rd) fault_count++;
      if (fault_count == 0) begin
         $display("resp_request_deframer verification clean");
      end else begin
         $display("resp_request_deframer verification failed");
      end
      $finish;
   end

endmodule
